[design/c2sp_pkg.sv]
package c2sp_pkg;

	localparam int COORD_WIDTH_DEF   = 24;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam int REFL_WIDTH   = 16;
	localparam int ACC_WIDTH    = 32;
	localparam int CF_BITS      = 16;
	localparam int CORDIC_WIDTH = 52;
	localparam int TAB_LEN      = 24;

	localparam logic [ACC_WIDTH-1:0] ACC_HALF_TURN = 32'h8000_0000;

	localparam logic [ACC_WIDTH-1:0] ATAN_TAB [TAB_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

endpackage

[design/c2sp_sqrt_cell.sv]
module c2sp_sqrt_cell #(
	parameter int SQW = 32
) (
	input  logic                clk,
	input  logic                en,
	input  logic [2*SQW-1:0]    rad_in,
	input  logic [SQW+2:0]      rem_in,
	input  logic [SQW-1:0]      root_in,
	output logic [2*SQW-1:0]    rad_out,
	output logic [SQW+2:0]      rem_out,
	output logic [SQW-1:0]      root_out
);

	localparam int RADW = 2 * SQW;
	localparam int REMW = SQW + 3;

	logic [REMW-1:0] rem_sh;
	logic [REMW-1:0] trial;
	logic            fits;
	logic [RADW-1:0] rad_q;
	logic [REMW-1:0] rem_q;
	logic [SQW-1:0]  root_q;

	assign rem_sh = {rem_in[REMW-3:0], rad_in[RADW-1:RADW-2]};
	assign trial  = REMW'({root_in, 2'b01});
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad_in << 2;
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_in[SQW-2:0], fits};
		end
	end

	assign rad_out  = rad_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;

endmodule

[design/c2sp_cordic_cell.sv]
module c2sp_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                                        clk,
	input  logic                                        en,
	input  logic signed [c2sp_pkg::CORDIC_WIDTH-1:0]    a_in,
	input  logic signed [c2sp_pkg::CORDIC_WIDTH-1:0]    b_in,
	input  logic [c2sp_pkg::ACC_WIDTH-1:0]              acc_in,
	output logic signed [c2sp_pkg::CORDIC_WIDTH-1:0]    a_out,
	output logic signed [c2sp_pkg::CORDIC_WIDTH-1:0]    b_out,
	output logic [c2sp_pkg::ACC_WIDTH-1:0]              acc_out
);

	logic signed [c2sp_pkg::CORDIC_WIDTH-1:0] a_sh;
	logic signed [c2sp_pkg::CORDIC_WIDTH-1:0] b_sh;
	logic signed [c2sp_pkg::CORDIC_WIDTH-1:0] a_q;
	logic signed [c2sp_pkg::CORDIC_WIDTH-1:0] b_q;
	logic [c2sp_pkg::ACC_WIDTH-1:0]           acc_q;

	assign a_sh = a_in >>> IDX;
	assign b_sh = b_in >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!b_in[c2sp_pkg::CORDIC_WIDTH-1]) begin
				a_q   <= a_in + b_sh;
				b_q   <= b_in - a_sh;
				acc_q <= acc_in + c2sp_pkg::ATAN_TAB[IDX];
			end else begin
				a_q   <= a_in - b_sh;
				b_q   <= b_in + a_sh;
				acc_q <= acc_in - c2sp_pkg::ATAN_TAB[IDX];
			end
		end
	end

	assign a_out   = a_q;
	assign b_out   = b_q;
	assign acc_out = acc_q;

endmodule

[design/c2sp_skid.sv]
module c2sp_skid #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic         out_valid_q;
	logic         spare_valid_q;
	logic [W-1:0] out_data_q;
	logic [W-1:0] spare_data_q;

	assign in_ready = !spare_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (spare_valid_q) begin
			if (out_ready) begin
				spare_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= in_valid;
		end else if (in_valid) begin
			spare_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (spare_valid_q) begin
			if (out_ready) begin
				out_data_q <= spare_data_q;
			end
		end else if (!out_valid_q || out_ready) begin
			out_data_q <= in_data;
		end else begin
			spare_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[design/cartesian_to_spherical_point_core.sv]
// Converts one scan point per cycle from Cartesian x, y, z to range, azimuth
// atan2(z, x) and elevation atan2(y, sqrt(x*x + z*z)), with angles in units of
// pi / 2^(ANGLE_WIDTH-1) and the range rounded down. Reflectance, coordinates and
// the last mark travel alongside unchanged. A new request is taken every cycle
// while the output buffer has room; when it is full, the whole pipeline stalls.
// The square-root cells give one result bit per cell for a root SQW bits wide,
// where SQW is the larger of 32 and COORD_WIDTH + 1; the CORDIC cells that
// follow give one rotation per cell. A two-entry output buffer keeps the input
// side open while a finished result waits to be taken.
module cartesian_to_spherical_point_core #(
	parameter int  COORD_WIDTH   = c2sp_pkg::COORD_WIDTH_DEF,
	parameter int  ANGLE_WIDTH   = c2sp_pkg::ANGLE_WIDTH_DEF,
	parameter int  CORDIC_STAGES = c2sp_pkg::CORDIC_STAGES_DEF,
	localparam int IN_DW  = ((3 * COORD_WIDTH + c2sp_pkg::REFL_WIDTH + 7) / 8) * 8,
	localparam int OUT_DW =
		((2 * ANGLE_WIDTH + 4 * COORD_WIDTH + c2sp_pkg::REFL_WIDTH + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// coord_x, coord_y, coord_z, reflectance_in
	input  logic [IN_DW-1:0]  s_axis_tdata,
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// azimuth, elevation, range_d, reflectance_out, out_x, out_y, out_z
	output logic [OUT_DW-1:0] m_axis_tdata,
	output logic              m_axis_tlast
);

	localparam int CW    = COORD_WIDTH;
	localparam int AW    = ANGLE_WIDTH;
	localparam int NS    = CORDIC_STAGES;
	localparam int RW    = c2sp_pkg::REFL_WIDTH;
	localparam int ACW   = c2sp_pkg::ACC_WIDTH;
	localparam int CDW   = c2sp_pkg::CORDIC_WIDTH;
	localparam int G     = ACW - CW;
	localparam int SQW   = (CW + 1 > ACW) ? CW + 1 : ACW;
	localparam int RADW  = 2 * SQW;
	localparam int REMW  = SQW + 3;
	localparam int SH    = G + c2sp_pkg::CF_BITS;
	localparam int NPAY  = 3 + SQW + NS;
	localparam int PREP  = 2 + SQW;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [RW-1:0]        refl;
		logic                 last;
		logic                 hz;
		logic                 dz;
		logic [CW-1:0]        rng;
	} pay_t;

	typedef struct packed {
		logic                 last;
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] x;
		logic [RW-1:0]        refl;
		logic [CW-1:0]        rng;
		logic signed [AW-1:0] el;
		logic signed [AW-1:0] az;
	} res_t;

	logic                 en;
	logic signed [CW-1:0] in_x;
	logic signed [CW-1:0] in_y;
	logic signed [CW-1:0] in_z;
	logic signed [2*CW-1:0] x_sq;
	logic signed [2*CW-1:0] y_sq;
	logic signed [2*CW-1:0] z_sq;

	logic [2*CW-1:0] sxx_s1;
	logic [2*CW-1:0] syy_s1;
	logic [2*CW-1:0] szz_s1;
	logic [2*CW-1:0] hsum;
	logic [2*CW-1:0] tot;
	logic [RADW-1:0] rad_h_s2;
	logic [RADW-1:0] rad_d_s2;

	logic        vld_q [NPAY+1];
	pay_t        pay_q [NPAY];
	pay_t        pay_fl;
	pay_t        pay_rg;

	logic [RADW-1:0] rad_h [SQW+1];
	logic [REMW-1:0] rem_h [SQW+1];
	logic [SQW-1:0]  root_h [SQW+1];
	logic [RADW-1:0] rad_d [SQW+1];
	logic [REMW-1:0] rem_d [SQW+1];
	logic [SQW-1:0]  root_d [SQW+1];

	logic signed [CDW-1:0] az_a_q;
	logic signed [CDW-1:0] az_b_q;
	logic [ACW-1:0]        az_acc_q;
	logic signed [CDW-1:0] el_a_q;
	logic signed [CDW-1:0] el_b_q;

	logic signed [CDW-1:0] az_a [NS+1];
	logic signed [CDW-1:0] az_b [NS+1];
	logic [ACW-1:0]        az_acc [NS+1];
	logic signed [CDW-1:0] el_a [NS+1];
	logic signed [CDW-1:0] el_b [NS+1];
	logic [ACW-1:0]        el_acc [NS+1];

	logic signed [CDW-1:0] xs;
	logic signed [CDW-1:0] zs;
	logic [CW-1:0]         dsat;
	logic [ACW-1:0]        az_rnd;
	logic [ACW-1:0]        el_rnd;
	res_t                  res_q;
	res_t                  res_out;

	assign in_x = s_axis_tdata[CW-1:0];
	assign in_y = s_axis_tdata[2*CW-1:CW];
	assign in_z = s_axis_tdata[3*CW-1:2*CW];
	assign x_sq = in_x * in_x;
	assign y_sq = in_y * in_y;
	assign z_sq = in_z * in_z;

	assign hsum = sxx_s1 + szz_s1;
	assign tot  = hsum + syy_s1;

	assign xs   = CDW'(pay_q[PREP-1].x) <<< SH;
	assign zs   = CDW'(pay_q[PREP-1].z) <<< SH;
	assign dsat = (|root_d[SQW][SQW-1:CW]) ? '1 : root_d[SQW][CW-1:0];

	assign az_rnd = az_acc[NS] + (ACW'(1) << (ACW - AW - 1));
	assign el_rnd = el_acc[NS] + (ACW'(1) << (ACW - AW - 1));

	always_comb begin
		pay_fl     = pay_q[0];
		pay_fl.hz  = (hsum == '0);
		pay_fl.dz  = (tot == '0);
		pay_rg     = pay_q[PREP-1];
		pay_rg.rng = dsat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NPAY; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= s_axis_tvalid;
			for (int k = 1; k <= NPAY; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q[0].x    <= in_x;
			pay_q[0].y    <= in_y;
			pay_q[0].z    <= in_z;
			pay_q[0].refl <= s_axis_tdata[3*CW+RW-1:3*CW];
			pay_q[0].last <= s_axis_tlast;
			pay_q[0].hz   <= 1'b0;
			pay_q[0].dz   <= 1'b0;
			pay_q[0].rng  <= '0;
			for (int k = 1; k < NPAY; k++) begin
				if (k == 1) begin
					pay_q[k] <= pay_fl;
				end else if (k == PREP) begin
					pay_q[k] <= pay_rg;
				end else begin
					pay_q[k] <= pay_q[k-1];
				end
			end

			sxx_s1 <= $unsigned(x_sq);
			syy_s1 <= $unsigned(y_sq);
			szz_s1 <= $unsigned(z_sq);

			rad_h_s2 <= RADW'(hsum) << (2 * G);
			rad_d_s2 <= RADW'(tot);

			if (pay_q[PREP-1].x[CW-1]) begin
				az_a_q   <= -xs;
				az_b_q   <= -zs;
				az_acc_q <= c2sp_pkg::ACC_HALF_TURN;
			end else begin
				az_a_q   <= xs;
				az_b_q   <= zs;
				az_acc_q <= '0;
			end
			el_a_q <= CDW'($signed({1'b0, root_h[SQW]})) <<< c2sp_pkg::CF_BITS;
			el_b_q <= CDW'(pay_q[PREP-1].y) <<< SH;

			res_q.last <= pay_q[NPAY-1].last;
			res_q.x    <= pay_q[NPAY-1].x;
			res_q.y    <= pay_q[NPAY-1].y;
			res_q.z    <= pay_q[NPAY-1].z;
			res_q.refl <= pay_q[NPAY-1].refl;
			res_q.rng  <= pay_q[NPAY-1].rng;
			res_q.az   <= pay_q[NPAY-1].hz ? '0 : az_rnd[ACW-1 -: AW];
			res_q.el   <= pay_q[NPAY-1].dz ? '0 : el_rnd[ACW-1 -: AW];
		end
	end

	assign rad_h[0]  = rad_h_s2;
	assign rem_h[0]  = '0;
	assign root_h[0] = '0;
	assign rad_d[0]  = rad_d_s2;
	assign rem_d[0]  = '0;
	assign root_d[0] = '0;

	for (genvar j = 0; j < SQW; j++) begin : g_sqrt
		c2sp_sqrt_cell #(.SQW(SQW)) u_h (
			.clk      (clk),
			.en       (en),
			.rad_in   (rad_h[j]),
			.rem_in   (rem_h[j]),
			.root_in  (root_h[j]),
			.rad_out  (rad_h[j+1]),
			.rem_out  (rem_h[j+1]),
			.root_out (root_h[j+1])
		);
		c2sp_sqrt_cell #(.SQW(SQW)) u_d (
			.clk      (clk),
			.en       (en),
			.rad_in   (rad_d[j]),
			.rem_in   (rem_d[j]),
			.root_in  (root_d[j]),
			.rad_out  (rad_d[j+1]),
			.rem_out  (rem_d[j+1]),
			.root_out (root_d[j+1])
		);
	end

	assign az_a[0]   = az_a_q;
	assign az_b[0]   = az_b_q;
	assign az_acc[0] = az_acc_q;
	assign el_a[0]   = el_a_q;
	assign el_b[0]   = el_b_q;
	assign el_acc[0] = '0;

	for (genvar c = 0; c < NS; c++) begin : g_cordic
		c2sp_cordic_cell #(.IDX(c)) u_az (
			.clk     (clk),
			.en      (en),
			.a_in    (az_a[c]),
			.b_in    (az_b[c]),
			.acc_in  (az_acc[c]),
			.a_out   (az_a[c+1]),
			.b_out   (az_b[c+1]),
			.acc_out (az_acc[c+1])
		);
		c2sp_cordic_cell #(.IDX(c)) u_el (
			.clk     (clk),
			.en      (en),
			.a_in    (el_a[c]),
			.b_in    (el_b[c]),
			.acc_in  (el_acc[c]),
			.a_out   (el_a[c+1]),
			.b_out   (el_b[c+1]),
			.acc_out (el_acc[c+1])
		);
	end

	c2sp_skid #(.W($bits(res_t))) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_q[NPAY]),
		.in_data   (res_q),
		.in_ready  (en),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res_out)
	);

	assign s_axis_tready = en;
	assign m_axis_tlast  = res_out.last;
	assign m_axis_tdata  = OUT_DW'({res_out.z, res_out.y, res_out.x, res_out.refl,
		res_out.rng, res_out.el, res_out.az});

`ifndef SYNTH
	// A blocked input side means a result is waiting at the output.
	a_block_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input blocked with no result pending");

	// The last pipeline stage holds while the output buffer is full.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |=> $stable(vld_q[NPAY]))
		else $error("pipeline advanced during stall");

	// A point on the vertical axis has zero azimuth.
	a_axis_azimuth: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_out.x == '0 && res_out.z == '0) |-> res_out.az == '0)
		else $error("nonzero azimuth for x and z both zero");

	// The origin has zero elevation and zero range.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_out.x == '0 && res_out.y == '0 && res_out.z == '0)
		|-> (res_out.el == '0 && res_out.rng == '0))
		else $error("nonzero elevation or range at origin");
`endif

endmodule

[tb/sv/cartesian_to_spherical_point_core_tb.sv]
`timescale 1ns / 1ps

module cartesian_to_spherical_point_core_tb;

	localparam int CW     = c2sp_pkg::COORD_WIDTH_DEF;
	localparam int AW     = c2sp_pkg::ANGLE_WIDTH_DEF;
	localparam int STAGES = c2sp_pkg::CORDIC_STAGES_DEF;
	localparam int RW     = c2sp_pkg::REFL_WIDTH;
	localparam int IN_DW  = ((3 * CW + RW + 7) / 8) * 8;
	localparam int OUT_DW = ((2 * AW + 4 * CW + RW + 7) / 8) * 8;
	localparam int LATENCY = 52;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic [CW-1:0] z;
		logic [CW-1:0] y;
		logic [CW-1:0] x;
		logic [RW-1:0] refl;
		logic [CW-1:0] range_d;
		logic [AW-1:0] elevation;
		logic [AW-1:0] azimuth;
	} point_result_t;

	typedef struct packed {
		point_result_t data;
		logic          last;
	} expected_point_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_DW-1:0]  s_axis_tdata;
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_DW-1:0] m_axis_tdata;
	logic              m_axis_tlast;

	expected_point_t spherical_queue[$];
	int error_count;
	int points_sent;
	int points_checked;
	int idle_cycles;
	bit idle_on;
	int stall_left;

	cartesian_to_spherical_point_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] cordic_angle(longint a, longint b);
		logic [31:0] acc;
		longint na;
		acc = '0;
		if (a < 0) begin
			a = -a;
			b = -b;
			acc = c2sp_pkg::ACC_HALF_TURN;
		end
		for (int i = 0; i < STAGES && i < c2sp_pkg::TAB_LEN; i++) begin
			if (b >= 0) begin
				na = a + (b >>> i);
				b = b - (a >>> i);
				acc = acc + c2sp_pkg::ATAN_TAB[i];
			end else begin
				na = a - (b >>> i);
				b = b + (a >>> i);
				acc = acc - c2sp_pkg::ATAN_TAB[i];
			end
			a = na;
		end
		return acc;
	endfunction

	function automatic logic [AW-1:0] round_angle(logic [31:0] acc);
		logic [31:0] r;
		r = (acc + (32'd1 << (31 - AW))) >> (32 - AW);
		return r[AW-1:0];
	endfunction

	function automatic expected_point_t predict_spherical(logic [IN_DW-1:0] req, logic last);
		expected_point_t e;
		longint x, y, z, h;
		longint unsigned hsum, d;
		x = longint'(signed'(req[0 +: CW]));
		y = longint'(signed'(req[CW +: CW]));
		z = longint'(signed'(req[2 * CW +: CW]));
		hsum = longint'(x * x) + longint'(z * z);
		d = int_sqrt(hsum + longint'(y * y));
		e.data.azimuth = '0;
		e.data.elevation = '0;
		if (hsum != 0)
			e.data.azimuth = round_angle(cordic_angle(x * (64'sd1 << (32 - CW + 16)),
				z * (64'sd1 << (32 - CW + 16))));
		if (d != 0) begin
			h = longint'(int_sqrt(hsum << (2 * (32 - CW))));
			e.data.elevation = round_angle(cordic_angle(h * 65536,
				y * (64'sd1 << (32 - CW)) * 65536));
		end
		if (d > ((64'd1 << CW) - 1))
			d = (64'd1 << CW) - 1;
		e.data.range_d = d[CW-1:0];
		e.data.refl = req[3 * CW +: RW];
		e.data.x = req[0 +: CW];
		e.data.y = req[CW +: CW];
		e.data.z = req[2 * CW +: CW];
		e.last = last;
		return e;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on result %0d: %s got %0h expected %0h",
			points_checked, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			spherical_queue = {spherical_queue,
				predict_spherical(s_axis_tdata, s_axis_tlast)};
	end

	always @(posedge clk) begin
		point_result_t got;
		expected_point_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(point_result_t)-1:0];
			if (spherical_queue.size() == 0) begin
				report_mismatch("unexpected result", got.range_d, 0);
			end else begin
				want = spherical_queue.pop_front();
				if (got.azimuth !== want.data.azimuth)
					report_mismatch("azimuth", got.azimuth, want.data.azimuth);
				if (got.elevation !== want.data.elevation)
					report_mismatch("elevation", got.elevation, want.data.elevation);
				if (got.range_d !== want.data.range_d)
					report_mismatch("range_d", got.range_d, want.data.range_d);
				if (got.refl !== want.data.refl)
					report_mismatch("reflectance", got.refl, want.data.refl);
				if (got.x !== want.data.x)
					report_mismatch("x", got.x, want.data.x);
				if (got.y !== want.data.y)
					report_mismatch("y", got.y, want.data.y);
				if (got.z !== want.data.z)
					report_mismatch("z", got.z, want.data.z);
				if (m_axis_tlast !== want.last)
					report_mismatch("last", m_axis_tlast, want.last);
			end
			points_checked++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", spherical_queue.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
			logic [RW-1:0] refl, logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DW'({refl, z, y, x});
		s_axis_tlast <= last;
		forever begin
			@(negedge clk);
			if (s_axis_tready) begin
				@(posedge clk);
				break;
			end
		end
		points_sent++;
	endtask

	function automatic logic [CW-1:0] rand_coord();
		return CW'($urandom);
	endfunction

	function automatic logic [CW-1:0] rand_small();
		return CW'($urandom_range(0, 64) - 32);
	endfunction

	task automatic test_directed_points();
		logic [CW-1:0] pmax, pmin, one, neg1;
		pmax = {1'b0, {(CW-1){1'b1}}};
		pmin = {1'b1, {(CW-1){1'b0}}};
		one = CW'(1);
		neg1 = '1;
		send_point('0, '0, '0, '0, 1'b0);
		send_point('0, '0, '0, '1, 1'b1);
		send_point(one, '0, '0, 16'h1234, 1'b0);
		send_point(neg1, '0, '0, 16'h8001, 1'b0);
		send_point(pmin, '0, '0, '0, 1'b0);
		send_point('0, '0, one, '0, 1'b0);
		send_point('0, '0, neg1, '0, 1'b0);
		send_point('0, pmax, '0, '0, 1'b0);
		send_point('0, pmin, '0, '0, 1'b1);
		send_point('0, one, '0, '0, 1'b0);
		send_point(pmax, pmax, pmax, '1, 1'b0);
		send_point(pmin, pmin, pmin, '0, 1'b1);
		send_point(pmax, pmin, pmax, 16'h5555, 1'b0);
		send_point(pmin, pmax, pmin, 16'haaaa, 1'b0);
		send_point(pmin, '0, pmax, '0, 1'b0);
		send_point(pmax, '0, pmin, '0, 1'b0);
		send_point(neg1, neg1, neg1, '0, 1'b0);
		send_point(one, one, one, '0, 1'b0);
		send_point(neg1, one, one, '0, 1'b1);
		send_point(pmin, one, neg1, '0, 1'b0);
	endtask

	task automatic test_random_points(int count);
		for (int i = 0; i < count; i++)
			send_point(rand_coord(), rand_coord(), rand_coord(), RW'($urandom), 1'($urandom));
	endtask

	task automatic test_near_axis_points(int count);
		int sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 3);
			case (sel)
				0: send_point(rand_small(), rand_small(), rand_small(), RW'($urandom), 1'($urandom));
				1: send_point(rand_coord(), rand_coord(), rand_small(), RW'($urandom), 1'b0);
				2: send_point(rand_small(), rand_coord(), rand_small(), RW'($urandom), 1'b0);
				default: send_point('0, rand_coord(), '0, RW'($urandom), 1'($urandom));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		points_sent = 0;
		idle_on = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_points();
		test_random_points(400);
		test_near_axis_points(200);
		idle_on = 1'b0;
		test_random_points(100);
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;
		while (spherical_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d points and checked %0d spherical results,", points_sent,
			points_checked);
		$display("covering axes, the origin, full-scale corners and random points.");
		if (error_count == 0 && spherical_queue.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[sim.f]
design/c2sp_pkg.sv
design/c2sp_sqrt_cell.sv
design/c2sp_cordic_cell.sv
design/c2sp_skid.sv
design/cartesian_to_spherical_point_core.sv
tb/sv/cartesian_to_spherical_point_core_tb.sv
